// ===== src/tcce_pkg.sv =====
package tcce_pkg;

  // screen geometry
  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int COPY_COUNT = CELL_COUNT - COLUMNS;

  localparam int COL_W = $clog2(COLUMNS);
  localparam int ROW_W = $clog2(ROWS);
  localparam int IDX_W = $clog2(CELL_COUNT);

  // port field widths
  localparam int COL_OUT_W  = 7;
  localparam int ROW_OUT_W  = 5;
  localparam int POS_W      = 11;
  localparam int CELL_IN_W  = 11;
  localparam int CHAR_W     = 8;
  localparam int COLOR_W    = 8;
  localparam int TAB_W      = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;
  localparam int CELL_W     = COLOR_W + CHAR_W;

  localparam logic [CHAR_W-1:0] CODE_BACKSPACE = 8'h08;
  localparam logic [CHAR_W-1:0] CODE_TAB       = 8'h09;
  localparam logic [CHAR_W-1:0] CODE_LINEFEED  = 8'h0a;
  localparam logic [CHAR_W-1:0] CODE_RETURN    = 8'h0d;
  localparam logic [CHAR_W-1:0] CODE_SPACE     = 8'h20;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TEXT_COLOR = 1'b0,
    REG_TAB_LENGTH = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    KIND_PRINT,
    KIND_RETURN,
    KIND_LINEFEED,
    KIND_TAB,
    KIND_BACKSPACE
  } char_kind_e;

  typedef enum logic [2:0] {
    CUR_HOLD,
    CUR_HOME,
    CUR_NEWLINE,
    CUR_BACK,
    CUR_ADVANCE
  } cur_op_e;

  typedef enum logic [1:0] {
    SWEEP_NONE,
    SWEEP_CLEAR,
    SWEEP_SCROLL
  } sweep_e;

  typedef enum logic [1:0] {
    SRC_ZERO,
    SRC_BLANK,
    SRC_COPY,
    SRC_CHAR
  } wr_src_e;

  typedef struct packed {
    logic    capture;
    cur_op_e cur_op;
    logic    tab_load;
    logic    tab_dec;
    sweep_e  sweep;
    logic    put_write;
    logic    read_issue;
    logic    load_result;
  } cmd_t;

  typedef struct packed {
    logic       is_read;
    char_kind_e kind;
    logic       col_last;
    logic       row_last;
    logic       tab_done;
    logic       sweep_last;
    logic       out_free;
  } status_t;

endpackage

// ===== src/tcce_ctrl.sv =====
module tcce_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  tcce_pkg::status_t status_i,
  output tcce_pkg::cmd_t    cmd_o
);
  import tcce_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_TAB,
    ST_SCROLL,
    ST_RESULT
  } state_e;

  state_e state_q, state_d;
  logic   wrap_scroll;

  // advancing from the bottom right cell scrolls the screen
  assign wrap_scroll = status_i.col_last && status_i.row_last;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.sweep = SWEEP_CLEAR;
        if (status_i.sweep_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (status_i.is_read) begin
          cmd_o.read_issue = 1'b1;
          state_d          = ST_RESULT;
        end else begin
          unique case (status_i.kind)
            KIND_RETURN: begin
              cmd_o.cur_op = CUR_HOME;
              state_d      = ST_RESULT;
            end
            KIND_LINEFEED: begin
              cmd_o.cur_op = CUR_NEWLINE;
              state_d      = status_i.row_last ? ST_SCROLL : ST_RESULT;
            end
            KIND_TAB: begin
              cmd_o.tab_load = 1'b1;
              state_d        = ST_TAB;
            end
            KIND_BACKSPACE: begin
              cmd_o.cur_op = CUR_BACK;
              state_d      = ST_RESULT;
            end
            KIND_PRINT: begin
              cmd_o.put_write = 1'b1;
              cmd_o.cur_op    = CUR_ADVANCE;
              state_d         = wrap_scroll ? ST_SCROLL : ST_RESULT;
            end
            default: state_d = ST_RESULT;
          endcase
        end
      end
      ST_TAB: begin
        if (status_i.tab_done) begin
          state_d = ST_RESULT;
        end else begin
          cmd_o.cur_op  = CUR_ADVANCE;
          cmd_o.tab_dec = 1'b1;
          if (wrap_scroll) state_d = ST_SCROLL;
        end
      end
      ST_SCROLL: begin
        cmd_o.sweep = SWEEP_SCROLL;
        if (status_i.sweep_last) begin
          // a tab may still have steps left after the scroll
          state_d = (!status_i.is_read && status_i.kind == KIND_TAB) ? ST_TAB : ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (status_i.out_free) begin
          cmd_o.load_result = 1'b1;
          state_d           = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== src/tcce_datapath.sv =====
module tcce_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  tcce_pkg::cmd_t                      cmd_i,
  output tcce_pkg::status_t                   status_o,
  input  logic                                cfg_valid_i,
  input  logic [tcce_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [tcce_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                action_i,
  input  logic [tcce_pkg::CHAR_W-1:0]         char_code_i,
  input  logic [tcce_pkg::CELL_IN_W-1:0]      cell_index_i,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output logic [tcce_pkg::COL_OUT_W-1:0]      cursor_col_o,
  output logic [tcce_pkg::ROW_OUT_W-1:0]      cursor_row_o,
  output logic [tcce_pkg::POS_W-1:0]          cursor_pos_o,
  output logic [tcce_pkg::CHAR_W-1:0]         read_char_o,
  output logic [tcce_pkg::COLOR_W-1:0]        read_color_o
);
  import tcce_pkg::*;

  logic [COLOR_W-1:0]   text_color_q;
  logic [TAB_W-1:0]     tab_length_q;

  logic                 action_q;
  logic [CHAR_W-1:0]    char_q;
  logic [CELL_IN_W-1:0] cell_q;
  char_kind_e           kind;

  logic [COL_W-1:0]     col_q, col_d;
  logic [ROW_W-1:0]     row_q, row_d;
  logic                 col_last, row_last;
  logic [IDX_W-1:0]     cur_addr;

  logic [TAB_W-1:0]     steps_q;
  logic [IDX_W-1:0]     sweep_q;
  logic                 sweep_last, sweep_copy;

  logic                 wr_en_q, wr_en_d;
  logic [IDX_W-1:0]     wr_addr_q, wr_addr_d;
  wr_src_e              wr_src_q, wr_src_d;
  logic [CELL_W-1:0]    wdata;

  logic [CELL_W-1:0]    mem_q [CELL_COUNT];
  logic                 rd_en;
  logic [IDX_W-1:0]     rd_addr;
  logic [CELL_W-1:0]    rdata_q;
  logic                 cell_ok;
  logic                 rd_hit_q;

  logic                 out_valid_q;
  logic [COL_OUT_W-1:0] out_col_q;
  logic [ROW_OUT_W-1:0] out_row_q;
  logic [POS_W-1:0]     out_pos_q;
  logic [CELL_W-1:0]    out_cell_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_color_q <= COLOR_W'(7);
      tab_length_q <= TAB_W'(4);
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_TEXT_COLOR: text_color_q <= cfg_data_i[COLOR_W-1:0];
        REG_TAB_LENGTH: tab_length_q <= cfg_data_i[TAB_W-1:0];
        default: ;
      endcase
    end
  end

  // item capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      action_q <= action_i;
      char_q   <= char_code_i;
      cell_q   <= cell_index_i;
    end
  end

  always_comb begin
    unique case (char_q)
      CODE_RETURN:    kind = KIND_RETURN;
      CODE_LINEFEED:  kind = KIND_LINEFEED;
      CODE_TAB:       kind = KIND_TAB;
      CODE_BACKSPACE: kind = KIND_BACKSPACE;
      default:        kind = KIND_PRINT;
    endcase
  end

  // cursor
  assign col_last = (col_q == COL_W'(COLUMNS - 1));
  assign row_last = (row_q == ROW_W'(ROWS - 1));
  assign cur_addr = IDX_W'(int'(row_q) * COLUMNS + int'(col_q));

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    unique case (cmd_i.cur_op)
      CUR_HOLD: ;
      CUR_HOME: col_d = '0;
      CUR_NEWLINE: begin
        col_d = '0;
        if (!row_last) row_d = row_q + 1'b1;
      end
      CUR_BACK: begin
        if (col_q != '0) begin
          col_d = col_q - 1'b1;
        end else if (row_q != '0) begin
          row_d = row_q - 1'b1;
          col_d = COL_W'(COLUMNS - 1);
        end
      end
      CUR_ADVANCE: begin
        if (col_last) begin
          col_d = '0;
          if (!row_last) row_d = row_q + 1'b1;
        end else begin
          col_d = col_q + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      steps_q <= '0;
      sweep_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      if (cmd_i.tab_load) begin
        steps_q <= tab_length_q;
      end else if (cmd_i.tab_dec) begin
        steps_q <= steps_q - 1'b1;
      end
      if (cmd_i.sweep != SWEEP_NONE) begin
        sweep_q <= sweep_last ? '0 : sweep_q + 1'b1;
      end
    end
  end

  assign sweep_last = (sweep_q == IDX_W'(CELL_COUNT - 1));
  assign sweep_copy = (cmd_i.sweep == SWEEP_SCROLL) && (sweep_q < IDX_W'(COPY_COUNT));

  // write port, registered behind the command so copies line up with the read data
  always_comb begin
    wr_en_d   = 1'b0;
    wr_addr_d = wr_addr_q;
    wr_src_d  = wr_src_q;
    if (cmd_i.sweep != SWEEP_NONE) begin
      wr_en_d   = 1'b1;
      wr_addr_d = sweep_q;
      if (cmd_i.sweep == SWEEP_CLEAR) begin
        wr_src_d = SRC_ZERO;
      end else begin
        wr_src_d = sweep_copy ? SRC_COPY : SRC_BLANK;
      end
    end else if (cmd_i.put_write) begin
      wr_en_d   = 1'b1;
      wr_addr_d = cur_addr;
      wr_src_d  = SRC_CHAR;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_en_q <= 1'b0;
    end else begin
      wr_en_q <= wr_en_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wr_addr_q <= wr_addr_d;
    wr_src_q  <= wr_src_d;
  end

  always_comb begin
    case (wr_src_q)
      SRC_ZERO:  wdata = '0;
      SRC_BLANK: wdata = {text_color_q, CODE_SPACE};
      SRC_COPY:  wdata = rdata_q;
      SRC_CHAR:  wdata = {text_color_q, char_q};
      default:   wdata = '0;
    endcase
  end

  // screen store
  assign cell_ok = (int'(cell_q) < CELL_COUNT);

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = IDX_W'(cell_q);
    if (sweep_copy) begin
      rd_en   = 1'b1;
      rd_addr = IDX_W'(int'(sweep_q) + COLUMNS);
    end else if (cmd_i.read_issue && cell_ok) begin
      rd_en = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_q) mem_q[wr_addr_q] <= wdata;
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) rdata_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.read_issue) rd_hit_q <= cell_ok;
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_result) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_result) begin
      out_col_q  <= COL_OUT_W'(col_q);
      out_row_q  <= ROW_OUT_W'(row_q);
      out_pos_q  <= POS_W'(cur_addr);
      out_cell_q <= (action_q && rd_hit_q) ? rdata_q : '0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign cursor_col_o = out_col_q;
  assign cursor_row_o = out_row_q;
  assign cursor_pos_o = out_pos_q;
  assign read_char_o  = out_cell_q[CHAR_W-1:0];
  assign read_color_o = out_cell_q[CELL_W-1:CHAR_W];

  always_comb begin
    status_o            = '0;
    status_o.is_read    = action_q;
    status_o.kind       = kind;
    status_o.col_last   = col_last;
    status_o.row_last   = row_last;
    status_o.tab_done   = (steps_q == '0);
    status_o.sweep_last = sweep_last;
    status_o.out_free   = !out_valid_q || out_ready_i;
  end

endmodule

// ===== src/text_console_character_engine_core.sv =====
// Teletype engine for an 80 x 25 text screen of 16-bit cells (character in the low
// byte, color above). Each item either puts one character (carriage return, line
// feed, tab, backspace or a printable byte) or reads one cell, and returns one
// result with the cursor after the item. After reset the screen store is cleared
// one cell per cycle, and no item is taken until that finishes. A put or read
// passes through accept, execute and load result; a tab adds one cursor step per
// unit of tab_length. Any scroll moves the whole store up one row through its
// single read and write port, one cell per cycle.
// The result register lets the next item be accepted while a result waits.
module text_console_character_engine_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [tcce_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [tcce_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                action_i,
  input  logic [tcce_pkg::CHAR_W-1:0]         char_code_i,
  input  logic [tcce_pkg::CELL_IN_W-1:0]      cell_index_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [tcce_pkg::COL_OUT_W-1:0]      cursor_col_o,
  output logic [tcce_pkg::ROW_OUT_W-1:0]      cursor_row_o,
  output logic [tcce_pkg::POS_W-1:0]          cursor_pos_o,
  output logic [tcce_pkg::CHAR_W-1:0]         read_char_o,
  output logic [tcce_pkg::COLOR_W-1:0]        read_color_o
);
  import tcce_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign cfg_ready_o = 1'b1;

  tcce_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  tcce_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .action_i     (action_i),
    .char_code_i  (char_code_i),
    .cell_index_i (cell_index_i),
    .out_ready_i  (out_ready_i),
    .out_valid_o  (out_valid_o),
    .cursor_col_o (cursor_col_o),
    .cursor_row_o (cursor_row_o),
    .cursor_pos_o (cursor_pos_o),
    .read_char_o  (read_char_o),
    .read_color_o (read_color_o)
  );

  // one item in flight: an accepted item closes the input until its result is loaded
  a_single_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted while an item is still in work");

  a_cursor_on_screen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (int'(cursor_col_o) < COLUMNS) && (int'(cursor_row_o) < ROWS))
    else $error("cursor off screen");

  a_pos_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      cursor_pos_o == POS_W'(int'(cursor_row_o) * COLUMNS + int'(cursor_col_o)))
    else $error("linear cursor position disagrees with row and column");

endmodule

// ===== bench/text_console_character_engine_core_tb.sv =====
module text_console_character_engine_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tcce_pkg::*;

  localparam logic ACT_PUT  = 1'b0;
  localparam logic ACT_READ = 1'b1;
  localparam int   IDLE_PCT    = 32;
  localparam int   HOLD_CYCLES = 400;
  localparam int   MAX_REPORTS = 10;

  typedef struct packed {
    logic                 action;
    logic [CHAR_W-1:0]    char_code;
    logic [CELL_IN_W-1:0] cell_index;
  } console_item_t;

  typedef struct packed {
    logic [COL_OUT_W-1:0] col;
    logic [ROW_OUT_W-1:0] row;
    logic [POS_W-1:0]     pos;
    logic [CHAR_W-1:0]    rchar;
    logic [COLOR_W-1:0]   rcolor;
  } cursor_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  cfg_reg_e              cfg_index = REG_TEXT_COLOR;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  action = ACT_PUT;
  logic [CHAR_W-1:0]     char_code = '0;
  logic [CELL_IN_W-1:0]  cell_index = '0;

  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [COL_OUT_W-1:0]  cursor_col;
  logic [ROW_OUT_W-1:0]  cursor_row;
  logic [POS_W-1:0]      cursor_pos;
  logic [CHAR_W-1:0]     read_char;
  logic [COLOR_W-1:0]    read_color;

  // predicted screen and cursor
  logic [CELL_W-1:0]  screen_mem [CELL_COUNT];
  int                 cur_col = 0;
  int                 cur_row = 0;
  logic [COLOR_W-1:0] text_color = 8'd7;
  logic [TAB_W-1:0]   tab_len = 4'd4;

  console_item_t  pending_chars [$];
  cursor_result_t expected_cursors [$];

  int  cycle_count = 0;
  int  cycle_limit = 30000;
  int  mismatches = 0;
  int  put_count = 0;
  int  read_count = 0;
  int  scroll_count = 0;
  int  reg_writes = 0;
  bit  in_taken = 1'b0;
  bit  sender_calm = 1'b0;
  bit  receiver_calm = 1'b0;
  int  hold_asked = 0;
  int  hold_served = 0;
  int  hold_left = 0;

  text_console_character_engine_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .action_i     (action),
    .char_code_i  (char_code),
    .cell_index_i (cell_index),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .cursor_col_o (cursor_col),
    .cursor_row_o (cursor_row),
    .cursor_pos_o (cursor_pos),
    .read_char_o  (read_char),
    .read_color_o (read_color)
  );

  always #2 clk_i = ~clk_i;

  task automatic shift_screen_up();
    for (int i = 0; i < COPY_COUNT; i++) screen_mem[i] = screen_mem[i + COLUMNS];
    for (int i = COPY_COUNT; i < CELL_COUNT; i++) screen_mem[i] = {text_color, CODE_SPACE};
    scroll_count++;
  endtask

  task automatic step_right();
    cur_col++;
    if (cur_col >= COLUMNS) begin
      cur_col = 0;
      cur_row++;
      if (cur_row >= ROWS) begin
        shift_screen_up();
        cur_row = ROWS - 1;
      end
    end
  endtask

  task automatic console_step(input console_item_t it, output cursor_result_t r);
    int linear;
    r = '0;
    if (it.action == ACT_PUT) begin
      put_count++;
      case (it.char_code)
        CODE_RETURN: cur_col = 0;
        CODE_LINEFEED: begin
          if (cur_row >= ROWS - 1) begin
            shift_screen_up();
            cur_row = ROWS - 1;
          end else begin
            cur_row++;
          end
          cur_col = 0;
        end
        CODE_TAB: for (int i = 0; i < int'(tab_len); i++) step_right();
        CODE_BACKSPACE: begin
          if (cur_col > 0) begin
            cur_col--;
          end else if (cur_row > 0) begin
            cur_row--;
            cur_col = COLUMNS - 1;
          end
        end
        default: begin
          screen_mem[cur_row * COLUMNS + cur_col] = {text_color, it.char_code};
          step_right();
        end
      endcase
    end else begin
      read_count++;
      linear = int'(it.cell_index);
      if (linear < CELL_COUNT) begin
        r.rchar  = screen_mem[linear][CHAR_W-1:0];
        r.rcolor = screen_mem[linear][CELL_W-1:CHAR_W];
      end
    end
    r.col = COL_OUT_W'(cur_col);
    r.row = ROW_OUT_W'(cur_row);
    r.pos = POS_W'(cur_row * COLUMNS + cur_col);
  endtask

  task automatic queue_item(input logic act, input logic [CHAR_W-1:0] code,
                            input logic [CELL_IN_W-1:0] linear);
    console_item_t  it;
    cursor_result_t r;
    int             scrolls_before;
    it.action = act;
    it.char_code = code;
    it.cell_index = linear;
    scrolls_before = scroll_count;
    console_step(it, r);
    expected_cursors.push_back(r);
    pending_chars.push_back(it);
    // each scroll walks the whole store once
    cycle_limit += 400 + 8000 * (scroll_count - scrolls_before);
  endtask

  task automatic queue_char(input logic [CHAR_W-1:0] code);
    queue_item(ACT_PUT, code, CELL_IN_W'($urandom_range(0, 2047)));
  endtask

  task automatic queue_read(input int linear);
    queue_item(ACT_READ, CHAR_W'($urandom_range(0, 255)), CELL_IN_W'(linear));
  endtask

  task automatic queue_random(input int count);
    int roll;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < 15) queue_read($urandom_range(0, 2047));
      else if (roll < 25) queue_char(CODE_LINEFEED);
      else if (roll < 30) queue_char(CODE_RETURN);
      else if (roll < 38) queue_char(CODE_TAB);
      else if (roll < 45) queue_char(CODE_BACKSPACE);
      else queue_char(CHAR_W'($urandom_range(0, 255)));
    end
  endtask

  // drive the cursor to the bottom right and push it over the edge in every way
  task automatic corner_sequence();
    while (cur_row < ROWS - 1) queue_char(CODE_LINEFEED);
    queue_char(CODE_RETURN);
    repeat (5) queue_char(CODE_TAB);
    repeat (4) queue_char(8'h2e);
    queue_char(8'h5a);
    queue_read(COPY_COUNT - 1);
    queue_read(CELL_COUNT - 1);
    repeat (5) queue_char(CODE_TAB);
    queue_char(CODE_TAB);
    queue_char(CODE_LINEFEED);
    queue_read(COPY_COUNT);
  endtask

  task automatic cfg_write(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk_i); while (!cfg_ready);
    if (idx == REG_TEXT_COLOR) text_color = data;
    else tab_len = data[TAB_W-1:0];
    reg_writes++;
    cycle_limit += 200;
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (pending_chars.size() != 0 || expected_cursors.size() != 0) @(posedge clk_i);
  endtask

  // sender
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid || in_taken)) begin
      if (pending_chars.size() != 0 &&
          (sender_calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
        in_valid   <= 1'b1;
        action     <= pending_chars[0].action;
        char_code  <= pending_chars[0].char_code;
        cell_index <= pending_chars[0].cell_index;
        void'(pending_chars.pop_front());
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver, with a long hold-off on request
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (hold_served != hold_asked) begin
      hold_served = hold_asked;
      hold_left = HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= receiver_calm || $urandom_range(0, 99) >= IDLE_PCT;
    end
  end

  // result checker
  always @(posedge clk_i) begin
    cursor_result_t want;
    bit             bad;
    cycle_count++;
    in_taken = in_valid && in_ready;
    if (rst_ni && out_valid && out_ready) begin
      if (expected_cursors.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected item: col %0d row %0d pos %0d char %h color %h",
                   cursor_col, cursor_row, cursor_pos, read_char, read_color);
      end else begin
        want = expected_cursors.pop_front();
        bad = (cursor_col != want.col) || (cursor_row != want.row) ||
              (cursor_pos != want.pos) || (read_char != want.rchar) ||
              (read_color != want.rcolor);
        if (bad) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display({"mismatch: exp col %0d row %0d pos %0d char %h color %h, ",
                      "got col %0d row %0d pos %0d char %h color %h"},
                     want.col, want.row, want.pos, want.rchar, want.rcolor,
                     cursor_col, cursor_row, cursor_pos, read_char, read_color);
        end
      end
    end
  end

  initial begin
    while (cycle_count < cycle_limit) @(posedge clk_i);
    $display("timeout after %0d cycles", cycle_count);
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    for (int n = 0; n < CELL_COUNT; n++) screen_mem[n] = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset values of color and tab, cleared store, edge cases of each code
    queue_read(0);
    queue_read(2047);
    queue_read(CELL_COUNT);
    queue_char(CODE_BACKSPACE);
    queue_char(8'h00);
    queue_char(8'hff);
    queue_char(CODE_SPACE);
    queue_read(1);
    queue_char(CODE_BACKSPACE);
    queue_char(CODE_TAB);
    queue_char(CODE_RETURN);
    queue_char(CODE_LINEFEED);
    queue_char(CODE_BACKSPACE);
    queue_char(8'h41);
    queue_read(COLUMNS - 1);
    queue_char(CODE_BACKSPACE);
    queue_char(CODE_TAB);
    queue_read(CELL_COUNT - 1);
    queue_read(1024);
    queue_char(8'h7f);
    queue_char(CODE_RETURN);
    drain();

    cfg_write(REG_TEXT_COLOR, 8'h00);
    cfg_write(REG_TAB_LENGTH, 8'h00);
    queue_char(CODE_TAB);
    queue_char(8'h55);
    queue_char(CODE_TAB);
    queue_read(0);
    queue_random(100);
    drain();

    // no idling on either side here
    cfg_write(REG_TEXT_COLOR, 8'hff);
    cfg_write(REG_TAB_LENGTH, 8'h0f);
    sender_calm = 1'b1;
    receiver_calm = 1'b1;
    corner_sequence();
    queue_random(150);
    drain();

    // receiver stalls while items keep coming
    receiver_calm = 1'b0;
    cfg_write(REG_TEXT_COLOR, CFG_DATA_W'($urandom_range(0, 255)));
    cfg_write(REG_TAB_LENGTH, CFG_DATA_W'($urandom_range(0, 255)));
    hold_asked++;
    queue_random(150);
    drain();
    sender_calm = 1'b0;

    cfg_write(REG_TEXT_COLOR, CFG_DATA_W'($urandom_range(0, 255)));
    cfg_write(REG_TAB_LENGTH, 8'h01);
    queue_random(120);
    drain();

    cfg_write(REG_TEXT_COLOR, 8'ha5);
    cfg_write(REG_TAB_LENGTH, 8'h04);
    queue_random(130);
    drain();

    repeat (20) @(posedge clk_i);
    $display("ran %0d puts and %0d reads, %0d scrolls, %0d register writes, %0d cycles",
             put_count, read_count, scroll_count, reg_writes, cycle_count);
    $display("mismatches %0d, items still awaited %0d", mismatches, expected_cursors.size());
    if (mismatches == 0 && expected_cursors.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
